// File: rtl/core/rtpdpk_pkg.sv
package rtpdpk_pkg;

  // Counter slots of the frame descriptor
  localparam int unsigned NUM_CNT = 8;
  localparam logic [2:0] C_IDR    = 3'd0;
  localparam logic [2:0] C_NONIDR = 3'd1;
  localparam logic [2:0] C_SEI    = 3'd2;
  localparam logic [2:0] C_SPS    = 3'd3;
  localparam logic [2:0] C_PPS    = 3'd4;
  localparam logic [2:0] C_VPS    = 3'd5;
  localparam logic [2:0] C_OTHER  = 3'd6;
  localparam logic [2:0] C_ERR    = 3'd7;

  // Start code is three zero bytes then this one
  localparam logic [7:0] SC_LAST_BYTE = 8'h01;
  localparam logic [2:0] SC_LEN       = 3'd4;

  // Codec selection
  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  typedef struct packed {
    logic [63:0]              ts;
    logic                     complete;
    logic [NUM_CNT-1:0][15:0] cnt;
  } desc_t;

  // Work for the output side produced by one input word
  typedef struct packed {
    logic       pre_vld;
    desc_t      pre;
    logic       sc;
    logic [1:0] nb;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       post_vld;
    desc_t      post;
  } cmd_t;

endpackage

// File: rtl/core/rtpdpk_in_if.sv
interface rtpdpk_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_packet;
  logic        last_of_packet;
  logic [15:0] pkt_len;
  logic [15:0] seq_num;
  logic [31:0] rtp_timestamp;
  logic [63:0] ext_ts;
  logic        marker_bit;

  modport source (
    output valid, data_byte, first_of_packet, last_of_packet, pkt_len,
           seq_num, rtp_timestamp, ext_ts, marker_bit,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_of_packet, last_of_packet, pkt_len,
           seq_num, rtp_timestamp, ext_ts, marker_bit,
    output ready
  );
endinterface

// File: rtl/core/rtpdpk_out_if.sv
interface rtpdpk_out_if;
  logic        valid;
  logic        ready;
  logic        frame_end;
  logic [7:0]  out_byte;
  logic [63:0] frame_timestamp;
  logic        frame_complete;
  logic [15:0] idr_units;
  logic [15:0] non_idr_units;
  logic [15:0] sei_units;
  logic [15:0] sps_units;
  logic [15:0] pps_units;
  logic [15:0] vps_units;
  logic [15:0] other_units;
  logic [15:0] error_count;

  modport source (
    output valid, frame_end, out_byte, frame_timestamp, frame_complete, idr_units,
           non_idr_units, sei_units, sps_units, pps_units, vps_units, other_units,
           error_count,
    input  ready
  );
  modport sink (
    input  valid, frame_end, out_byte, frame_timestamp, frame_complete, idr_units,
           non_idr_units, sei_units, sps_units, pps_units, vps_units, other_units,
           error_count,
    output ready
  );
endinterface

// File: rtl/core/rtpdpk_front.sv
module rtpdpk_front #(
  parameter int unsigned MAX_FRAME_BYTES = 2097152,
  parameter int unsigned COUNT_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rtpdpk_in_if.sink          in_i,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               q_full_i,
  output logic               push_o,
  output rtpdpk_pkg::cmd_t   cmd_o
);

  localparam int unsigned FB_W  = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned SUM_W = FB_W + 18;

  typedef enum logic [2:0] {
    M_IDLE, M_SKIP, M_COPY, M_SIZE_HI, M_SIZE_LO, M_FU_HDR, M_AGG_BODY, M_AGG_DISCARD
  } mode_e;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  logic                     codec_q;
  logic                     frm_open_q, frm_open_d;
  logic [31:0]              cur_rtp_q, cur_rtp_d;
  logic [63:0]              cur_ext_q, cur_ext_d;
  logic [15:0]              prev_q, prev_d;
  logic                     complete_q, complete_d;
  logic                     video_q, video_d;
  logic [FB_W-1:0]          fb_q, fb_d;
  cnt_t                     cnt_q [rtpdpk_pkg::NUM_CNT];
  cnt_t                     cnt_d [rtpdpk_pkg::NUM_CNT];
  logic [15:0]              off_q, off_d;
  mode_e                    mode_q, mode_d;
  logic [15:0]              urem_q, urem_d;
  logic [15:0]              saved_q, saved_d;
  logic                     drop_q, drop_d;

  logic fire;
  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && !q_full_i;

  // Map a NAL header byte to its counter slot and video flag
  function automatic logic [3:0] classify(logic [7:0] h, logic codec);
    logic [4:0] t4;
    logic [5:0] t5;
    logic [3:0] r;
    t4 = h[4:0];
    t5 = h[6:1];
    r  = {1'b1, rtpdpk_pkg::C_OTHER};
    if (codec == rtpdpk_pkg::CODEC_H264) begin
      unique case (t4) inside
        5'd5:    r = {1'b1, rtpdpk_pkg::C_IDR};
        5'd6:    r = {1'b0, rtpdpk_pkg::C_SEI};
        5'd7:    r = {1'b0, rtpdpk_pkg::C_SPS};
        5'd8:    r = {1'b0, rtpdpk_pkg::C_PPS};
        default: r = (t4 != 5'd0 && t4 < 5'd24) ? {1'b1, rtpdpk_pkg::C_NONIDR}
                                                : {1'b1, rtpdpk_pkg::C_OTHER};
      endcase
    end else begin
      unique case (t5) inside
        6'd19, 6'd20: r = {1'b1, rtpdpk_pkg::C_IDR};
        6'd32:        r = {1'b0, rtpdpk_pkg::C_VPS};
        6'd33:        r = {1'b0, rtpdpk_pkg::C_SPS};
        6'd34:        r = {1'b0, rtpdpk_pkg::C_PPS};
        6'd39, 6'd40: r = {1'b0, rtpdpk_pkg::C_SEI};
        default:      r = (t5 < 6'd48) ? {1'b1, rtpdpk_pkg::C_NONIDR}
                                       : {1'b1, rtpdpk_pkg::C_OTHER};
      endcase
    end
    return r;
  endfunction

  // Decode the word and update packet and frame state
  always_comb begin
    logic [7:0]       b;
    logic [15:0]      len;
    logic [15:0]      p;
    logic             abort, err, cls_en, agg_en, fu_start;
    logic [7:0]       cls_h, r0;
    logic [16:0]      agg_q;
    logic [15:0]      size, ur, body;
    logic [SUM_W-1:0] sum;
    logic [3:0]       cls;
    cnt_t             cv [rtpdpk_pkg::NUM_CNT];

    b   = in_i.data_byte;
    len = in_i.pkt_len;
    p   = off_q;
    abort = 1'b0; err = 1'b0; cls_en = 1'b0; agg_en = 1'b0; fu_start = 1'b0;
    cls_h = 8'h00; r0 = 8'h00; agg_q = '0; size = '0; ur = '0; body = '0;
    sum = '0; cls = '0;
    for (int i = 0; i < rtpdpk_pkg::NUM_CNT; i++) cv[i] = cnt_q[i];

    frm_open_d = frm_open_q; cur_rtp_d = cur_rtp_q; cur_ext_d = cur_ext_q;
    prev_d = prev_q; complete_d = complete_q; video_d = video_q; fb_d = fb_q;
    off_d = off_q; mode_d = mode_q; urem_d = urem_q; saved_d = saved_q;
    drop_d = drop_q;
    cmd_o = '0;

    if (fire) begin
      if (in_i.first_of_packet) begin
        // New timestamp closes the open frame
        if (!frm_open_q || in_i.rtp_timestamp != cur_rtp_q) begin
          if (frm_open_q && fb_q != '0) begin
            cmd_o.pre_vld      = 1'b1;
            cmd_o.pre.ts       = cur_ext_q;
            cmd_o.pre.complete = complete_q;
            for (int i = 0; i < rtpdpk_pkg::NUM_CNT; i++) begin
              cmd_o.pre.cnt[i] = 16'(cv[i]);
              cv[i] = '0;
            end
            fb_d    = '0;
            video_d = 1'b0;
          end
          frm_open_d = 1'b1;
          cur_rtp_d  = in_i.rtp_timestamp;
          cur_ext_d  = in_i.ext_ts;
          complete_d = 1'b1;
          prev_d     = in_i.seq_num - 16'd1;
        end
        drop_d = 1'b0;
        urem_d = '0;
        if (len == '0) begin
          abort = 1'b1;
        end else begin
          if (in_i.seq_num != prev_d + 16'd1) complete_d = 1'b0;
          prev_d = in_i.seq_num;
          if (codec_q == rtpdpk_pkg::CODEC_H264 && b[4:0] == 5'd24) begin
            agg_en = 1'b1; agg_q = 17'd1;
          end else if (codec_q == rtpdpk_pkg::CODEC_H265 && b[6:1] == 6'd48) begin
            agg_en = 1'b1; agg_q = 17'd2;
          end else if ((codec_q == rtpdpk_pkg::CODEC_H264 && b[4:0] == 5'd28) ||
                       (codec_q == rtpdpk_pkg::CODEC_H265 && b[6:1] == 6'd49)) begin
            if (len < ((codec_q == rtpdpk_pkg::CODEC_H264) ? 16'd2 : 16'd3)) begin
              abort = 1'b1;
            end else begin
              saved_d = {8'h00, b};
              mode_d  = M_FU_HDR;
            end
          end else begin
            sum = SUM_W'(fb_d) + SUM_W'(4) + SUM_W'(len);
            if (sum >= SUM_W'(MAX_FRAME_BYTES)) begin
              err    = 1'b1;
              mode_d = M_SKIP;
            end else begin
              cmd_o.sc = 1'b1;
              cmd_o.nb = 2'd1;
              cmd_o.b0 = b;
              cls_en   = 1'b1;
              cls_h    = b;
              fb_d     = FB_W'(sum);
              mode_d   = M_COPY;
            end
          end
        end
        off_d = 16'd1;
      end else if (mode_q != M_IDLE && off_q < len) begin
        unique case (mode_q) inside
          M_COPY: begin
            cmd_o.nb = 2'd1;
            cmd_o.b0 = b;
          end
          M_FU_HDR: begin
            if (codec_q == rtpdpk_pkg::CODEC_H265 && p == 16'd1) begin
              saved_d = {b, saved_q[7:0]};
            end else begin
              // Rebuild the NAL header from indicator and FU header
              fu_start = b[7];
              if (codec_q == rtpdpk_pkg::CODEC_H264)
                body = (len >= 16'd2) ? len - 16'd2 : 16'd0;
              else
                body = (len >= 16'd3) ? len - 16'd3 : 16'd0;
              sum = SUM_W'(fb_q) + SUM_W'(body);
              if (fu_start)
                sum = sum + ((codec_q == rtpdpk_pkg::CODEC_H264) ? SUM_W'(5) : SUM_W'(6));
              if (sum >= SUM_W'(MAX_FRAME_BYTES)) begin
                abort = 1'b1;
              end else begin
                if (fu_start) begin
                  cmd_o.sc = 1'b1;
                  if (codec_q == rtpdpk_pkg::CODEC_H264) begin
                    r0       = {saved_q[7:5], b[4:0]};
                    cmd_o.nb = 2'd1;
                  end else begin
                    r0       = {saved_q[7], b[5:0], saved_q[0]};
                    cmd_o.nb = 2'd2;
                    cmd_o.b1 = saved_q[15:8];
                  end
                  cmd_o.b0 = r0;
                  cls_en   = 1'b1;
                  cls_h    = r0;
                end
                fb_d   = FB_W'(sum);
                mode_d = M_COPY;
              end
            end
          end
          M_SIZE_HI: begin
            if (!(codec_q == rtpdpk_pkg::CODEC_H265 && p == 16'd1)) begin
              urem_d = {b, 8'h00};
              mode_d = M_SIZE_LO;
            end
          end
          M_SIZE_LO: begin
            size = {urem_q[15:8], b};
            if (size == '0 || (18'(p) + 18'd1 + 18'(size)) > 18'(len)) begin
              if (codec_q == rtpdpk_pkg::CODEC_H265) abort = 1'b1;
              else begin
                err    = 1'b1;
                mode_d = M_SKIP;
              end
            end else begin
              urem_d = size;
              sum    = SUM_W'(fb_q) + SUM_W'(4) + SUM_W'(size);
              if (sum >= SUM_W'(MAX_FRAME_BYTES)) begin
                if (codec_q == rtpdpk_pkg::CODEC_H265) abort = 1'b1;
                else begin
                  err    = 1'b1;
                  mode_d = M_AGG_DISCARD;
                end
              end else begin
                cmd_o.sc = 1'b1;
                fb_d     = FB_W'(sum);
                saved_d  = size;
                mode_d   = M_AGG_BODY;
              end
            end
          end
          M_AGG_BODY, M_AGG_DISCARD: begin
            ur = urem_q;
            if (ur != '0) begin
              if (mode_q == M_AGG_BODY) begin
                if (ur == saved_q) begin
                  cls_en = 1'b1;
                  cls_h  = b;
                end
                cmd_o.nb = 2'd1;
                cmd_o.b0 = b;
              end
              ur = ur - 16'd1;
            end
            urem_d = ur;
            if (ur == '0) begin
              agg_en = 1'b1;
              agg_q  = 17'(p) + 17'd1;
            end
          end
          default: ;
        endcase
        if (off_q != 16'hFFFF) off_d = off_q + 16'd1;
      end

      // Step to the next aggregation unit
      if (agg_en) begin
        if (agg_q + 17'd2 <= 17'(len)) mode_d = M_SIZE_HI;
        else if (codec_q == rtpdpk_pkg::CODEC_H265 && agg_q != 17'(len)) abort = 1'b1;
        else mode_d = M_SKIP;
      end

      // Drop the rest of the packet
      if (abort) begin
        drop_d = 1'b1;
        mode_d = M_SKIP;
      end

      // Count the unit type and any error in the same word, saturating
      cls = classify(cls_h, codec_q);
      if (cls_en && cls[3]) video_d = 1'b1;
      for (int i = 0; i < rtpdpk_pkg::NUM_CNT; i++) begin
        if (((cls_en && 3'(i) == cls[2:0]) ||
             ((abort || err) && 3'(i) == rtpdpk_pkg::C_ERR)) &&
            cv[i] != {COUNT_BITS{1'b1}})
          cv[i] = cv[i] + cnt_t'(1);
      end

      // Marker closes the frame once video is present
      if (in_i.last_of_packet && mode_d != M_IDLE) begin
        if (!drop_d && in_i.marker_bit && video_d && frm_open_d && fb_d != '0) begin
          cmd_o.post_vld      = 1'b1;
          cmd_o.post.ts       = cur_ext_d;
          cmd_o.post.complete = complete_d;
          for (int i = 0; i < rtpdpk_pkg::NUM_CNT; i++) begin
            cmd_o.post.cnt[i] = 16'(cv[i]);
            cv[i] = '0;
          end
          fb_d       = '0;
          frm_open_d = 1'b0;
          complete_d = 1'b1;
          video_d    = 1'b0;
        end
        mode_d = M_IDLE;
      end
    end
    for (int i = 0; i < rtpdpk_pkg::NUM_CNT; i++) cnt_d[i] = cv[i];
  end

  assign push_o = fire && (cmd_o.pre_vld || cmd_o.sc || cmd_o.nb != 2'd0 || cmd_o.post_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q    <= rtpdpk_pkg::CODEC_H264;
      frm_open_q <= 1'b0;
      cur_rtp_q  <= '0;
      cur_ext_q  <= '0;
      prev_q     <= '0;
      complete_q <= 1'b1;
      video_q    <= 1'b0;
      fb_q       <= '0;
      for (int i = 0; i < rtpdpk_pkg::NUM_CNT; i++) cnt_q[i] <= '0;
      off_q      <= '0;
      mode_q     <= M_IDLE;
      urem_q     <= '0;
      saved_q    <= '0;
      drop_q     <= 1'b0;
    end else begin
      if (cfg_we_i) codec_q <= cfg_wdata_i;
      frm_open_q <= frm_open_d;
      cur_rtp_q  <= cur_rtp_d;
      cur_ext_q  <= cur_ext_d;
      prev_q     <= prev_d;
      complete_q <= complete_d;
      video_q    <= video_d;
      fb_q       <= fb_d;
      for (int i = 0; i < rtpdpk_pkg::NUM_CNT; i++) cnt_q[i] <= cnt_d[i];
      off_q      <= off_d;
      mode_q     <= mode_d;
      urem_q     <= urem_d;
      saved_q    <= saved_d;
      drop_q     <= drop_d;
    end
  end

endmodule

// File: rtl/core/rtpdpk_queue.sv
module rtpdpk_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rtpdpk_pkg::cmd_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output rtpdpk_pkg::cmd_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rtpdpk_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // Hold the entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Advance the pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (!push_i && do_pop) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// File: rtl/core/rtpdpk_back.sv
module rtpdpk_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  rtpdpk_pkg::cmd_t q_data_i,
  output logic             pop_o,
  rtpdpk_out_if.source     out_o
);

  rtpdpk_pkg::cmd_t   cur_q, cur_d;
  logic [2:0]         sc_q, sc_d;
  logic [1:0]         nb_q, nb_d;
  logic               ovld_q, ovld_d;
  logic               oend_q, oend_d;
  logic [7:0]         obyte_q, obyte_d;
  rtpdpk_pkg::desc_t  odesc_q, odesc_d;

  // Pick the next word of the current entry
  always_comb begin
    logic slot;
    cur_d = cur_q; sc_d = sc_q; nb_d = nb_q;
    oend_d = oend_q; obyte_d = obyte_q; odesc_d = odesc_q;
    ovld_d = ovld_q && !out_o.ready;
    slot   = !ovld_q || out_o.ready;
    if (slot) begin
      if (cur_q.pre_vld) begin
        ovld_d = 1'b1; oend_d = 1'b1; obyte_d = 8'h00; odesc_d = cur_q.pre;
        cur_d.pre_vld = 1'b0;
      end else if (sc_q != '0) begin
        ovld_d = 1'b1; oend_d = 1'b0; odesc_d = '0;
        obyte_d = (sc_q == 3'd1) ? rtpdpk_pkg::SC_LAST_BYTE : 8'h00;
        sc_d = sc_q - 3'd1;
      end else if (nb_q != '0) begin
        ovld_d = 1'b1; oend_d = 1'b0; odesc_d = '0; obyte_d = cur_q.b0;
        cur_d.b0 = cur_q.b1;
        nb_d = nb_q - 2'd1;
      end else if (cur_q.post_vld) begin
        ovld_d = 1'b1; oend_d = 1'b1; obyte_d = 8'h00; odesc_d = cur_q.post;
        cur_d.post_vld = 1'b0;
      end
    end
    // Load the next entry once this one is spent
    pop_o = q_valid_i && !cur_d.pre_vld && sc_d == '0 && nb_d == '0 && !cur_d.post_vld;
    if (pop_o) begin
      cur_d = q_data_i;
      sc_d  = q_data_i.sc ? rtpdpk_pkg::SC_LEN : 3'd0;
      nb_d  = q_data_i.nb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      sc_q   <= '0;
      nb_q   <= '0;
      ovld_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      sc_q   <= sc_d;
      nb_q   <= nb_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oend_q  <= oend_d;
    obyte_q <= obyte_d;
    odesc_q <= odesc_d;
  end

  assign out_o.valid           = ovld_q;
  assign out_o.frame_end       = oend_q;
  assign out_o.out_byte        = obyte_q;
  assign out_o.frame_timestamp = odesc_q.ts;
  assign out_o.frame_complete  = odesc_q.complete;
  assign out_o.idr_units       = odesc_q.cnt[rtpdpk_pkg::C_IDR];
  assign out_o.non_idr_units   = odesc_q.cnt[rtpdpk_pkg::C_NONIDR];
  assign out_o.sei_units       = odesc_q.cnt[rtpdpk_pkg::C_SEI];
  assign out_o.sps_units       = odesc_q.cnt[rtpdpk_pkg::C_SPS];
  assign out_o.pps_units       = odesc_q.cnt[rtpdpk_pkg::C_PPS];
  assign out_o.vps_units       = odesc_q.cnt[rtpdpk_pkg::C_VPS];
  assign out_o.other_units     = odesc_q.cnt[rtpdpk_pkg::C_OTHER];
  assign out_o.error_count     = odesc_q.cnt[rtpdpk_pkg::C_ERR];

endmodule

// File: rtl/core/rtp_h26x_depacketizer_top.sv
// Channel   Dir  Word
// in_i      in   one RTP payload byte with its packet header fields
// out_o     out  one Annex-B byte, or a frame descriptor (frame_end high)
// cfg       in   cfg_we_i / cfg_wdata_i write codec_select (0 H.264, 1 H.265)
//
// The front end decodes one input word per cycle and queues the output work it
// causes; the back end sends one output word per cycle from a registered stage
// while out_o is ready. An input word makes up to seven output words, so start
// codes and descriptors stall the input only once the QUEUE_DEPTH-entry queue
// fills. Reset is asynchronous, active low, and needs no clearing pass.
module rtp_h26x_depacketizer_top #(
  parameter int unsigned MAX_FRAME_BYTES = 2097152,
  parameter int unsigned COUNT_BITS      = 16,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rtpdpk_in_if.sink    in_i,
  rtpdpk_out_if.source out_o,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i
);

  logic             push, full, pop, qvld;
  rtpdpk_pkg::cmd_t cmd_in, cmd_out;

  rtpdpk_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  rtpdpk_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qvld),
    .data_o (cmd_out)
  );

  rtpdpk_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(qvld),
    .q_data_i (cmd_out),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
